[hdl/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // header / payload phase of the parser
    typedef enum logic [2:0] {
        ST_LEN_HI  = 3'd0,
        ST_LEN_LO  = 3'd1,
        ST_RSV0    = 3'd2,
        ST_RSV1    = 3'd3,
        ST_PAYLOAD = 3'd4
    } t_hdr_state;

    // one received byte handed from the input stage to the parser
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_txn;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
        logic              empty_res;
        logic              header_error;
    } t_result;

endpackage

[hdl/lpd_in_reg.sv]
// ----------------------------------------------------------------------------
// lpd_in_reg
// Input register: captures one received byte per transaction and holds it
// until the parser consumes it.
// ----------------------------------------------------------------------------
module lpd_in_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                      i_take,
    output lpd_pkg::t_byte_txn        o_txn
);
    import lpd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    // free when empty or being drained this cycle
    assign o_in_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // byte holding register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_txn = '{valid: r_valid, data: r_data};

endmodule

[hdl/lpd_parse.sv]
// ----------------------------------------------------------------------------
// lpd_parse
// Header parser and result register: tracks the frame header, counts the
// payload down and registers one result per payload byte or empty frame.
// ----------------------------------------------------------------------------
module lpd_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpd_pkg::t_byte_txn i_txn,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpd_pkg::t_result   o_result
);
    import lpd_pkg::*;

    t_hdr_state       r_state, n_state, w_eff_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic             r_bad, n_bad;
    logic             r_out_valid;
    t_result          r_result;
    logic             w_out_free;
    logic             w_res_vld;
    t_result          w_res;
    logic             w_byte_nz;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_take     = i_txn.valid && w_out_free;
    assign w_byte_nz  = (i_txn.data != '0);

    // a payload phase with nothing left restarts at the first header byte
    assign w_eff_state = (r_state == ST_PAYLOAD && r_rem == '0) ? ST_LEN_HI : r_state;

    // next state
    always_comb begin
        n_state = r_state;
        if (o_take) begin
            unique case (w_eff_state)
                ST_LEN_HI:  n_state = ST_LEN_LO;
                ST_LEN_LO:  n_state = ST_RSV0;
                ST_RSV0:    n_state = ST_RSV1;
                ST_RSV1:    n_state = (r_len == '0) ? ST_LEN_HI : ST_PAYLOAD;
                ST_PAYLOAD: n_state = (r_rem == LEN_W'(1)) ? ST_LEN_HI : ST_PAYLOAD;
                default:    n_state = ST_LEN_LO;
            endcase
        end
    end

    // frame fields and result
    always_comb begin
        n_len     = r_len;
        n_rem     = r_rem;
        n_bad     = r_bad;
        w_res_vld = 1'b0;
        w_res     = '0;
        if (o_take) begin
            unique case (w_eff_state)
                ST_LEN_HI: begin
                    n_bad = 1'b0;
                    n_len = {i_txn.data, BYTE_W'(0)};
                end
                ST_LEN_LO: begin
                    n_len = {r_len[LEN_W-1:BYTE_W], i_txn.data};
                end
                ST_RSV0: begin
                    n_bad = r_bad | w_byte_nz;
                end
                ST_RSV1: begin
                    n_bad = r_bad | w_byte_nz;
                    n_rem = r_len;
                    if (r_len == '0) begin
                        w_res_vld          = 1'b1;
                        w_res.last         = 1'b1;
                        w_res.empty_res    = 1'b1;
                        w_res.header_error = r_bad | w_byte_nz;
                    end
                end
                ST_PAYLOAD: begin
                    n_rem              = r_rem - LEN_W'(1);
                    w_res_vld          = 1'b1;
                    w_res.payload_byte = i_txn.data;
                    w_res.last         = (r_rem == LEN_W'(1));
                    w_res.header_error = r_bad;
                end
                default: begin
                    n_bad = 1'b0;
                    n_len = {i_txn.data, BYTE_W'(0)};
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEN_HI;
            r_len   <= '0;
            r_rem   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_bad   <= n_bad;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_result <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

[hdl/length_prefixed_deframer_top.sv]
// Path: a payload byte is loaded into the input register and then into the result
//   register, which drives the output.
// Throughput: one byte per cycle while the receiver does not stall the output.
// Header bytes give no result, except the last one of a zero-length frame.
// Reset (synchronous, active low) empties both registers and restarts at the
//   first header byte.
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top
// Splits a byte stream into frames with a 4-byte length-and-reserved header
// and emits the payload bytes, last and error marked.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lpd_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                       o_last,
    output logic                       o_empty_res,
    output logic                       o_header_error
);
    import lpd_pkg::*;

    t_byte_txn w_txn;
    logic      w_take;
    t_result   w_result;

    // input register
    lpd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_txn      (w_txn)
    );

    // parser and result register
    lpd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_txn       (w_txn),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_payload_byte = w_result.payload_byte;
    assign o_last         = w_result.last;
    assign o_empty_res    = w_result.empty_res;
    assign o_header_error = w_result.header_error;

endmodule

[verif/deframer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches both channels of the length-prefixed deframer. It parses every
// accepted byte with its own copy of the header state and queues the result
// that the byte should cause. Each result transaction is then compared with
// the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module deframer_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [lpd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [lpd_pkg::BYTE_W-1:0] i_payload_byte,
    input  logic                       i_last,
    input  logic                       i_empty_res,
    input  logic                       i_header_error,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    import lpd_pkg::*;

    // parser state, mirrored from the block's behaviour
    t_hdr_state       hdr_phase;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] bytes_left;
    logic             rsv_bad;

    t_result pending_results[$];

    // Parse one received byte; returns 1 and fills frame_out when the byte
    // completes a result.
    function automatic logic parse_byte(input logic [BYTE_W-1:0] b,
                                        output t_result frame_out);
        frame_out = '0;
        // payload byte of the current frame
        if (hdr_phase == ST_PAYLOAD && bytes_left != 0) begin
            bytes_left = bytes_left - 1'b1;
            frame_out.payload_byte = b;
            frame_out.last         = (bytes_left == 0);
            frame_out.header_error = rsv_bad;
            if (bytes_left == 0)
                hdr_phase = ST_LEN_HI;
            return 1'b1;
        end
        // any other phase restarts on a first header byte
        if (!(hdr_phase inside {ST_LEN_HI, ST_LEN_LO, ST_RSV0, ST_RSV1}))
            hdr_phase = ST_LEN_HI;
        case (hdr_phase)
            ST_LEN_HI: begin
                rsv_bad   = 1'b0;
                frame_len = {b, 8'h00};
                hdr_phase = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                frame_len[7:0] = b;
                hdr_phase      = ST_RSV0;
            end
            ST_RSV0: begin
                if (b != 0)
                    rsv_bad = 1'b1;
                hdr_phase = ST_RSV1;
            end
            default: begin
                if (b != 0)
                    rsv_bad = 1'b1;
                // zero-length frame: one empty result, marked last
                if (frame_len == 0) begin
                    hdr_phase              = ST_LEN_HI;
                    bytes_left             = '0;
                    frame_out.last         = 1'b1;
                    frame_out.empty_res    = 1'b1;
                    frame_out.header_error = rsv_bad;
                    return 1'b1;
                end
                bytes_left = frame_len;
                hdr_phase  = ST_PAYLOAD;
            end
        endcase
        return 1'b0;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            hdr_phase  = ST_LEN_HI;
            frame_len  = '0;
            bytes_left = '0;
            rsv_bad    = 1'b0;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (parse_byte(i_rx_byte, want))
                    pending_results = {pending_results, want};
            end
            if (i_out_valid && i_out_ready) begin
                seen = '{i_payload_byte, i_last, i_empty_res, i_header_error};
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected: byte %02h last %0b empty %0b err %0b",
                             $time, seen.payload_byte, seen.last, seen.empty_res,
                             seen.header_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    o_checked <= o_checked + 1;
                    if (seen != want) begin
                        if (seen.payload_byte != want.payload_byte)
                            $display("%0t: payload_byte expected %02h actual %02h",
                                     $time, want.payload_byte, seen.payload_byte);
                        if (seen.last != want.last)
                            $display("%0t: last expected %0b actual %0b",
                                     $time, want.last, seen.last);
                        if (seen.empty_res != want.empty_res)
                            $display("%0t: empty_res expected %0b actual %0b",
                                     $time, want.empty_res, seen.empty_res);
                        if (seen.header_error != want.header_error)
                            $display("%0t: header_error expected %0b actual %0b",
                                     $time, want.header_error, seen.header_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= pending_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the length-prefixed deframer: a few hand-built
// frames covering empty frames, reserved-byte errors and byte extremes, one
// frame with a nonzero high length byte, then random frames, with random
// stalls on both channels. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module testbench;
    import lpd_pkg::*;

    localparam int RANDOM_BYTES = 1700;
    localparam int QUIET_FROM   = 1500;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [BYTE_W-1:0] o_payload_byte;
    logic              o_last;
    logic              o_empty_res;
    logic              o_header_error;

    int fail_count;
    int pending;
    int checked;

    int bytes_sent;
    int frames_sent;
    int err_frames;
    int in_idle_pct;
    int out_idle_pct;
    bit quiet;

    length_prefixed_deframer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_header_error (o_header_error)
    );

    deframer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_payload_byte (o_payload_byte),
        .i_last         (o_last),
        .i_empty_res    (o_empty_res),
        .i_header_error (o_header_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Present one byte, after an optional idle burst, and hold it until the
    // transaction is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // header then random payload
    task automatic send_frame(input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] rsv0,
                              input logic [BYTE_W-1:0] rsv1);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(rsv0);
        send_byte(rsv1);
        for (int k = 0; k < len; k++)
            send_byte(BYTE_W'($urandom));
        frames_sent++;
        if (rsv0 != 0 || rsv1 != 0)
            err_frames++;
    endtask

    // pick fresh idle rates so that calm and busy stretches alternate
    task automatic pick_idle_rates();
        int pick;
        pick = $urandom_range(0, 2);
        in_idle_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
        pick = $urandom_range(0, 2);
        out_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
    endtask

    // receiver stalls
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
                @(negedge i_clk) i_out_ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        int pick;
        logic [BYTE_W-1:0] rsv0;
        logic [BYTE_W-1:0] rsv1;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_rx_byte    = '0;
        quiet        = 1'b0;
        bytes_sent   = 0;
        frames_sent  = 0;
        err_frames   = 0;
        in_idle_pct  = 20;
        out_idle_pct = 20;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty frame, clean then with a reserved error
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
        // single-byte frame
        send_byte(8'h00); send_byte(8'h01); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hAB);
        // error in the second reserved byte, payload at the byte extremes
        send_byte(8'h00); send_byte(8'h02); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'h00); send_byte(8'hFF);
        // error in the first reserved byte
        send_byte(8'h00); send_byte(8'h03); send_byte(8'h80); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h5A);
        frames_sent = 5;
        err_frames  = 3;

        // length with a nonzero high byte, then a short frame on the boundary
        send_frame(16'h0100, 8'h00, 8'h00);
        send_frame(16'h0002, 8'h00, 8'h00);

        // random frames, mostly short
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            pick_idle_rates();
            quiet = (bytes_sent >= QUIET_FROM);
            pick  = $urandom_range(0, 99);
            if (pick < 10)
                len = 0;
            else if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 300);
            rsv0 = '0;
            rsv1 = '0;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                rsv0 = BYTE_W'($urandom_range(1, 255));
            else if (pick < 16)
                rsv1 = BYTE_W'($urandom_range(1, 255));
            else if (pick < 20) begin
                rsv0 = BYTE_W'($urandom_range(1, 255));
                rsv1 = BYTE_W'($urandom_range(1, 255));
            end
            send_frame(LEN_W'(len), rsv0, rsv1);
        end

        // drain: input idle, wait for every expected result, then a margin
        @(negedge i_clk) i_in_valid <= 1'b0;
        quiet = 1'b1;
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Frames sent: %0d (%0d with reserved errors, one of 256 bytes)",
                 frames_sent, err_frames);
        $display("Result transactions checked: %0d", checked);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // timeout
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
